FILE: src/segment_segment_intersection_top_assert.svh
// ----------------------------------------------------------------------------
// segment intersection assertion macros
// shared property wrappers, clocked on clk
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_INTERSECTION_TOP_ASSERT_SVH
`define SEGMENT_SEGMENT_INTERSECTION_TOP_ASSERT_SVH

// checked only outside reset
`define SSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SSI_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// widths, payload types and constants of the segment intersection block
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = 24;
  localparam int T_BITS     = 16;

  localparam int DIF_BITS = COORD_BITS + 1;        // coordinate differences
  localparam int PRD_BITS = 2 * DIF_BITS;          // difference products
  localparam int SUM_BITS = PRD_BITS + 1;          // cross products
  localparam int MAG_BITS = COORD_BITS;            // |dx|, |dy|
  localparam int CRS_BITS = 2 * COORD_BITS + 1;    // |c2|, |det|
  localparam int LEN_BITS = 2 * COORD_BITS + 1;    // squared length
  localparam int LO_BITS  = COORD_BITS + 1;        // low slice of |c2|
  localparam int HI_BITS  = CRS_BITS - LO_BITS;
  localparam int RQ_BITS  = COORD_BITS + FRAC_BITS;
  localparam int R_BITS   = RQ_BITS + 2;
  localparam int RP_BITS  = R_BITS + DIF_BITS;
  localparam int DOT_BITS = RP_BITS + 1;
  localparam int SH_BITS  = T_BITS - FRAC_BITS;
  localparam int NUM_BITS = DOT_BITS + SH_BITS;
  localparam int TQ_BITS  = T_BITS + 1;
  localparam int TX_BITS  = TQ_BITS + 1 + DIF_BITS;
  localparam int EXT_BITS = TX_BITS + FRAC_BITS + 1;
  localparam int RND      = (SH_BITS > 0) ? (1 << (SH_BITS - 1)) : 0;

  localparam int FIFO_DEPTH = 2;
  localparam int BACK_LAT   = RQ_BITS + TQ_BITS + 9;
  localparam int LATENCY    = RQ_BITS + TQ_BITS + 15;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] q1_x;
    logic signed [COORD_BITS-1:0] q1_y;
    logic signed [COORD_BITS-1:0] q2_x;
    logic signed [COORD_BITS-1:0] q2_y;
  } seg_t;

  typedef struct packed {
    logic                       found;
    logic signed [OUT_BITS-1:0] hit_x;
    logic signed [OUT_BITS-1:0] hit_y;
  } res_t;

  typedef struct packed {
    logic                         hit;
    logic signed [DIF_BITS-1:0]   dx;
    logic signed [DIF_BITS-1:0]   dy;
    logic signed [SUM_BITS-1:0]   c2;
    logic signed [SUM_BITS-1:0]   det;
    logic        [LEN_BITS-1:0]   len2;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
  } job_t;

  typedef struct packed {
    logic                         hit;
    logic                         neg;
    logic signed [DIF_BITS-1:0]   dx;
    logic signed [DIF_BITS-1:0]   dy;
    logic        [LEN_BITS-1:0]   len2;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
  } ptag_t;

  typedef struct packed {
    logic                         hit;
    logic                         zero;
    logic                         sat;
    logic signed [DIF_BITS-1:0]   dx;
    logic signed [DIF_BITS-1:0]   dy;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
  } ttag_t;

endpackage

FILE: src/ssi_div.sv
// ----------------------------------------------------------------------------
// ssi_div
// pipelined restoring divider, one quotient bit per stage, with side tag
// ----------------------------------------------------------------------------
module ssi_div #(
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int TW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DW+QW-1:0] in_num,
  input  logic [DW-1:0]    in_den,
  input  logic [TW-1:0]    in_tag,
  output logic             out_valid,
  output logic [QW-1:0]    out_quo,
  output logic [DW-1:0]    out_rem,
  output logic [DW-1:0]    out_den,
  output logic [TW-1:0]    out_tag
);

  logic [QW:0]   vld;
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] quo  [QW+1];
  logic [DW-1:0] den  [QW+1];
  logic [TW-1:0] tag  [QW+1];
  logic [DW:0]   trial [QW];
  logic [DW:0]   diff  [QW];
  logic          ge    [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  // numerator high part must stay below the divisor
  always_comb begin
    for (int i = 0; i < QW; i++) begin
      trial[i] = {rem[i], low[i][QW-1]};
      diff[i]  = trial[i] - {1'b0, den[i]};
      ge[i]    = trial[i] >= {1'b0, den[i]};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= in_num[DW+QW-1:QW];
    low[0] <= in_num[QW-1:0];
    quo[0] <= '0;
    den[0] <= in_den;
    tag[0] <= in_tag;
    for (int i = 0; i < QW; i++) begin
      rem[i+1] <= ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
      low[i+1] <= low[i] << 1;
      quo[i+1] <= (quo[i] << 1) | QW'(ge[i]);
      den[i+1] <= den[i];
      tag[i+1] <= tag[i];
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_rem   = rem[QW];
  assign out_den   = den[QW];
  assign out_tag   = tag[QW];

endmodule

FILE: src/ssi_front.sv
// ----------------------------------------------------------------------------
// ssi_front
// differences, cross products and the proper-crossing classification
// ----------------------------------------------------------------------------
module ssi_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  ssi_pkg::seg_t seg,
  output logic          push,
  output ssi_pkg::job_t job
);

  localparam int DB = ssi_pkg::DIF_BITS;
  localparam int PB = ssi_pkg::PRD_BITS;
  localparam int SB = ssi_pkg::SUM_BITS;

  logic v0, v1, v2, v3;
  ssi_pkg::seg_t s0;

  logic signed [DB-1:0] dx, dy, ex, ey, wx, wy, vx, vy, ax, ay;
  logic signed [ssi_pkg::COORD_BITS-1:0] p1x1, p1y1, p1x2, p1y2, p1x3, p1y3;
  logic signed [DB-1:0] dx2, dy2, dx3, dy3;

  logic signed [PB-1:0] m_dxwy, m_dywx, m_dxvy, m_dyvx, m_exwy, m_eywx;
  logic signed [PB-1:0] m_exay, m_eyax, m_dxey, m_dyex, m_dxdx, m_dydy;

  logic signed [SB-1:0] d1, d2, d4, c2, det, len2;
  logic                 hit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= take;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s0 <= seg;

    dx <= DB'(s0.p2_x) - DB'(s0.p1_x);
    dy <= DB'(s0.p2_y) - DB'(s0.p1_y);
    ex <= DB'(s0.q2_x) - DB'(s0.q1_x);
    ey <= DB'(s0.q2_y) - DB'(s0.q1_y);
    wx <= DB'(s0.q1_x) - DB'(s0.p1_x);
    wy <= DB'(s0.q1_y) - DB'(s0.p1_y);
    vx <= DB'(s0.q2_x) - DB'(s0.p1_x);
    vy <= DB'(s0.q2_y) - DB'(s0.p1_y);
    ax <= DB'(s0.p2_x) - DB'(s0.q1_x);
    ay <= DB'(s0.p2_y) - DB'(s0.q1_y);
    p1x1 <= s0.p1_x;
    p1y1 <= s0.p1_y;

    m_dxwy <= PB'(dx) * PB'(wy);
    m_dywx <= PB'(dy) * PB'(wx);
    m_dxvy <= PB'(dx) * PB'(vy);
    m_dyvx <= PB'(dy) * PB'(vx);
    m_exwy <= PB'(ex) * PB'(wy);
    m_eywx <= PB'(ey) * PB'(wx);
    m_exay <= PB'(ex) * PB'(ay);
    m_eyax <= PB'(ey) * PB'(ax);
    m_dxey <= PB'(dx) * PB'(ey);
    m_dyex <= PB'(dy) * PB'(ex);
    m_dxdx <= PB'(dx) * PB'(dx);
    m_dydy <= PB'(dy) * PB'(dy);
    dx2  <= dx;
    dy2  <= dy;
    p1x2 <= p1x1;
    p1y2 <= p1y1;

    // the test of P1, P2 against Q1-Q2 at P1 equals c2
    d1   <= SB'(m_dxwy) - SB'(m_dywx);
    d2   <= SB'(m_dxvy) - SB'(m_dyvx);
    d4   <= SB'(m_exay) - SB'(m_eyax);
    c2   <= SB'(m_eywx) - SB'(m_exwy);
    det  <= SB'(m_dxey) - SB'(m_dyex);
    len2 <= SB'(m_dxdx) + SB'(m_dydy);
    dx3  <= dx2;
    dy3  <= dy2;
    p1x3 <= p1x2;
    p1y3 <= p1y2;
  end

  // strictly opposite signs on both pairs
  always_comb begin
    hit_c = (d1 != '0) && (d2 != '0) && (d1[SB-1] != d2[SB-1]) &&
            (c2 != '0) && (d4 != '0) && (c2[SB-1] != d4[SB-1]) &&
            (det != '0);
  end

  always_comb begin
    push     = v3;
    job.hit  = hit_c;
    job.dx   = dx3;
    job.dy   = dy3;
    job.c2   = c2;
    job.det  = det;
    job.len2 = len2[ssi_pkg::LEN_BITS-1:0];
    job.p1_x = p1x3;
    job.p1_y = p1y3;
  end

endmodule

FILE: src/ssi_fifo.sv
// ----------------------------------------------------------------------------
// ssi_fifo
// short job queue between classifier and solver, registered read side
// ----------------------------------------------------------------------------
`include "segment_segment_intersection_top_assert.svh"

module ssi_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssi_pkg::job_t din,
  output logic          full,
  output logic          out_valid,
  output ssi_pkg::job_t dout
);

  localparam int AW = $clog2(ssi_pkg::FIFO_DEPTH);

  ssi_pkg::job_t mem [ssi_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count, count_next;
  logic          pop;

  // the solver never stalls, so the queue pops a job whenever it is not empty
  assign pop  = count != '0;
  assign full = count == (AW+1)'(ssi_pkg::FIFO_DEPTH);

  always_comb begin
    count_next = count + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count     <= count_next;
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
    if (pop) begin
      dout <= mem[rd_ptr];
    end
  end

  `SSI_ASSERT(a_fifo_no_overflow, (push |-> !full), "job pushed into full queue")

endmodule

FILE: src/ssi_back.sv
// ----------------------------------------------------------------------------
// ssi_back
// crossing point by Cramer's rule, projection onto P1-P2, output register
// ----------------------------------------------------------------------------
`include "segment_segment_intersection_top_assert.svh"

module ssi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ssi_pkg::job_t job,
  output logic          done,
  output ssi_pkg::res_t res
);

  localparam int MB  = ssi_pkg::MAG_BITS;
  localparam int CB  = ssi_pkg::CRS_BITS;
  localparam int LB  = ssi_pkg::LO_BITS;
  localparam int XL  = MB + LB;
  localparam int XH  = MB + ssi_pkg::HI_BITS;
  localparam int NX  = MB + CB;
  localparam int RQ  = ssi_pkg::RQ_BITS;
  localparam int RB  = ssi_pkg::R_BITS;
  localparam int RPB = ssi_pkg::RP_BITS;
  localparam int DTB = ssi_pkg::DOT_BITS;
  localparam int NB  = ssi_pkg::NUM_BITS;
  localparam int LNB = ssi_pkg::LEN_BITS;
  localparam int TQ  = ssi_pkg::TQ_BITS;
  localparam int TXB = ssi_pkg::TX_BITS;
  localparam int EB  = ssi_pkg::EXT_BITS;
  localparam int PTW = $bits(ssi_pkg::ptag_t);
  localparam int TTW = $bits(ssi_pkg::ttag_t);

  // stage b0: magnitudes and split products
  logic [MB-1:0] adx_c, ady_c;
  logic [CB-1:0] ac2_c, adet_c;
  logic          b0_v;
  logic [XL-1:0] pxl, pyl;
  logic [XH-1:0] pxh, pyh;
  logic [CB-1:0] adet0;
  ssi_pkg::ptag_t tag0;
  logic          negy0;

  // stage b1: full numerators
  logic          b1_v;
  logic [NX-1:0] nx, ny;
  logic [CB-1:0] adet1;
  ssi_pkg::ptag_t tag1;
  logic          negy1;

  // point dividers
  logic          dvx_v, dvy_v;
  logic [RQ-1:0] qx, qy;
  logic [CB-1:0] rx_rem, ry_rem, dx_den, dy_den;
  logic [PTW-1:0] dvx_tag;
  logic [0:0]    dvy_tag;
  ssi_pkg::ptag_t ptag;

  // stage b2: rounded point
  logic          upx_c, upy_c;
  logic [RQ:0]   mx_c, my_c;
  logic          b2_v;
  logic signed [RB-1:0] rx, ry;
  ssi_pkg::ptag_t tag2;

  // stage b3, b4: dot product
  logic          b3_v, b4_v;
  logic signed [RPB-1:0] prx, pry;
  logic signed [DTB-1:0] dot;
  ssi_pkg::ptag_t tag3, tag4;

  // t divider
  logic signed [NB-1:0] num_c;
  logic [NB-1:0]        ndot_c;
  logic                 zero_c, sat_c;
  logic [LNB+TQ-1:0]    tnum_c;
  ssi_pkg::ttag_t       ttag_c, ttag;
  logic                 dt_v;
  logic [TQ-1:0]        tq;
  logic [LNB-1:0]       t_rem, t_den;
  logic [TTW-1:0]       dt_tag;

  // stage b6, b7
  logic [TQ-1:0]        t_c;
  logic                 b6_v;
  logic signed [TXB-1:0] tx, ty;
  logic                 hit6;
  logic signed [ssi_pkg::COORD_BITS-1:0] p1x6, p1y6;
  logic signed [EB-1:0] hx_c, hy_c;

  always_comb begin
    adx_c  = MB'(job.dx[ssi_pkg::DIF_BITS-1] ? -job.dx : job.dx);
    ady_c  = MB'(job.dy[ssi_pkg::DIF_BITS-1] ? -job.dy : job.dy);
    ac2_c  = CB'(job.c2[ssi_pkg::SUM_BITS-1] ? -job.c2 : job.c2);
    adet_c = CB'(job.det[ssi_pkg::SUM_BITS-1] ? -job.det : job.det);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      b6_v <= 1'b0;
      done <= 1'b0;
    end else begin
      b0_v <= in_valid;
      b1_v <= b0_v;
      b2_v <= dvx_v;
      b3_v <= b2_v;
      b4_v <= b3_v;
      b6_v <= dt_v;
      done <= b6_v;
    end
  end

  always_ff @(posedge clk) begin
    pxl   <= XL'(adx_c) * XL'(ac2_c[LB-1:0]);
    pxh   <= XH'(adx_c) * XH'(ac2_c[CB-1:LB]);
    pyl   <= XL'(ady_c) * XL'(ac2_c[LB-1:0]);
    pyh   <= XH'(ady_c) * XH'(ac2_c[CB-1:LB]);
    adet0 <= adet_c;
    tag0.hit  <= job.hit;
    tag0.neg  <= job.dx[ssi_pkg::DIF_BITS-1] ^ job.c2[ssi_pkg::SUM_BITS-1] ^
                 job.det[ssi_pkg::SUM_BITS-1];
    tag0.dx   <= job.dx;
    tag0.dy   <= job.dy;
    tag0.len2 <= job.len2;
    tag0.p1_x <= job.p1_x;
    tag0.p1_y <= job.p1_y;
    negy0 <= job.dy[ssi_pkg::DIF_BITS-1] ^ job.c2[ssi_pkg::SUM_BITS-1] ^
             job.det[ssi_pkg::SUM_BITS-1];

    nx    <= tag0.hit ? NX'(pxl) + (NX'(pxh) << LB) : '0;
    ny    <= tag0.hit ? NX'(pyl) + (NX'(pyh) << LB) : '0;
    adet1 <= adet0;
    tag1  <= tag0;
    negy1 <= negy0;
  end

  ssi_div #(
    .DW(CB),
    .QW(RQ),
    .TW(PTW)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b1_v),
    .in_num   ((CB+RQ)'(nx) << ssi_pkg::FRAC_BITS),
    .in_den   (adet1),
    .in_tag   (tag1),
    .out_valid(dvx_v),
    .out_quo  (qx),
    .out_rem  (rx_rem),
    .out_den  (dx_den),
    .out_tag  (dvx_tag)
  );

  ssi_div #(
    .DW(CB),
    .QW(RQ),
    .TW(1)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b1_v),
    .in_num   ((CB+RQ)'(ny) << ssi_pkg::FRAC_BITS),
    .in_den   (adet1),
    .in_tag   (negy1),
    .out_valid(dvy_v),
    .out_quo  (qy),
    .out_rem  (ry_rem),
    .out_den  (dy_den),
    .out_tag  (dvy_tag)
  );

  // round to nearest, ties up: negative quotients round away only past half
  always_comb begin
    ptag  = dvx_tag;
    upx_c = ptag.neg ? ({rx_rem, 1'b0} > {1'b0, dx_den}) :
                       ({rx_rem, 1'b0} >= {1'b0, dx_den});
    upy_c = dvy_tag[0] ? ({ry_rem, 1'b0} > {1'b0, dy_den}) :
                         ({ry_rem, 1'b0} >= {1'b0, dy_den});
    mx_c  = (RQ+1)'(qx) + (RQ+1)'(upx_c);
    my_c  = (RQ+1)'(qy) + (RQ+1)'(upy_c);
  end

  always_ff @(posedge clk) begin
    rx   <= ptag.neg ? -RB'(mx_c) : RB'(mx_c);
    ry   <= dvy_tag[0] ? -RB'(my_c) : RB'(my_c);
    tag2 <= ptag;

    prx  <= RPB'(rx) * RPB'(tag2.dx);
    pry  <= RPB'(ry) * RPB'(tag2.dy);
    tag3 <= tag2;

    dot  <= DTB'(prx) + DTB'(pry);
    tag4 <= tag3;
  end

  // t below zero or degenerate first segment gives t = 0, t of 2 or more saturates
  always_comb begin
    num_c  = NB'(dot) <<< ssi_pkg::SH_BITS;
    ndot_c = num_c;
    zero_c = num_c[NB-1] || (tag4.len2 == '0);
    sat_c  = !zero_c && ((ndot_c >> TQ) >= NB'(tag4.len2));
    tnum_c = (zero_c || sat_c) ? '0 : ndot_c[LNB+TQ-1:0];
    ttag_c.hit  = tag4.hit;
    ttag_c.zero = zero_c;
    ttag_c.sat  = sat_c;
    ttag_c.dx   = tag4.dx;
    ttag_c.dy   = tag4.dy;
    ttag_c.p1_x = tag4.p1_x;
    ttag_c.p1_y = tag4.p1_y;
  end

  ssi_div #(
    .DW(LNB),
    .QW(TQ),
    .TW(TTW)
  ) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b4_v),
    .in_num   (tnum_c),
    .in_den   (tag4.len2),
    .in_tag   (ttag_c),
    .out_valid(dt_v),
    .out_quo  (tq),
    .out_rem  (t_rem),
    .out_den  (t_den),
    .out_tag  (dt_tag)
  );

  always_comb begin
    ttag = dt_tag;
    if (ttag.zero) begin
      t_c = '0;
    end else if (ttag.sat || (tq > TQ'(1 << ssi_pkg::T_BITS))) begin
      t_c = TQ'(1 << ssi_pkg::T_BITS);
    end else begin
      t_c = tq;
    end
  end

  always_ff @(posedge clk) begin
    tx   <= TXB'(signed'({1'b0, t_c})) * TXB'(ttag.dx);
    ty   <= TXB'(signed'({1'b0, t_c})) * TXB'(ttag.dy);
    hit6 <= ttag.hit;
    p1x6 <= ttag.p1_x;
    p1y6 <= ttag.p1_y;
  end

  always_comb begin
    hx_c = ((EB'(tx) + EB'(ssi_pkg::RND)) >>> ssi_pkg::SH_BITS) +
           (EB'(p1x6) <<< ssi_pkg::FRAC_BITS);
    hy_c = ((EB'(ty) + EB'(ssi_pkg::RND)) >>> ssi_pkg::SH_BITS) +
           (EB'(p1y6) <<< ssi_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    res.found <= hit6;
    res.hit_x <= hit6 ? hx_c[ssi_pkg::OUT_BITS-1:0] : '0;
    res.hit_y <= hit6 ? hy_c[ssi_pkg::OUT_BITS-1:0] : '0;
  end

  `SSI_ASSERT(a_back_miss_zero, (in_valid && !job.hit |-> ##(ssi_pkg::BACK_LAT) done && !res.found && res.hit_x == '0 && res.hit_y == '0), "miss did not come out empty")
  `SSI_ASSERT(a_back_lanes_align, (dvx_v == dvy_v), "point dividers out of step")

endmodule

FILE: src/segment_segment_intersection_top.sv
// ----------------------------------------------------------------------------
// segment_segment_intersection_top
// proper crossing test of two segments with a fixed-point crossing point
// ----------------------------------------------------------------------------
// Usage:
//   Drive seg (P1, P2, Q1, Q2 as signed integers) and raise start. A beat is
//   taken at a rising edge with start high and busy low. A new segment pair
//   may be taken on every cycle.
//   Each taken beat gives one result on res, marked by done for exactly one
//   cycle, in order. found is 1 only for a proper crossing; hit_x and hit_y
//   then hold the point projected onto P1-P2 with 8 fraction bits,
//   otherwise they are zero.
//   The crossing point and the projection parameter come from pipelined
//   restoring dividers, one quotient bit per stage: 24 stages for the
//   crossing point and 17 for the projection parameter.
//   Throughput is one pair per cycle; busy only rises if the job queue
//   between classifier and solver ever fills.
//   The receiver cannot stall; results must be taken when done is high.
//   Synchronous reset clears all valid flags; beats in flight are dropped.
// ----------------------------------------------------------------------------
`include "segment_segment_intersection_top_assert.svh"

module segment_segment_intersection_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ssi_pkg::seg_t seg,
  output logic          done,
  output ssi_pkg::res_t res
);

  logic          take;
  logic          push;
  logic          full;
  logic          job_v;
  ssi_pkg::job_t job_in, job_out;

  assign busy = full;
  assign take = start && !busy;

  ssi_front u_front (
    .clk (clk),
    .rst (rst),
    .take(take),
    .seg (seg),
    .push(push),
    .job (job_in)
  );

  ssi_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (job_in),
    .full     (full),
    .out_valid(job_v),
    .dout     (job_out)
  );

  ssi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(job_v),
    .job     (job_out),
    .done    (done),
    .res     (res)
  );

  `SSI_ASSERT(a_top_latency, (done |-> $past(start && !busy, ssi_pkg::LATENCY)), "result without matching beat")
  `SSI_ASSERT_NR(a_top_reset_quiet, (rst |=> !done), "done set right after reset")

endmodule
